// File: hdl/layer_pixel_blend_assert.svh
// Assertion macros for the layer pixel blend checker.
// Clocked on clk, disabled while rst is high; no other dependencies.
`ifndef LAYER_PIXEL_BLEND_ASSERT_SVH
`define LAYER_PIXEL_BLEND_ASSERT_SVH

// cond seen at an edge requires prop at the same edge
`define LPB_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// cond seen at an edge requires prop at the next edge
`define LPB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hdl/lpb_pkg.sv
// Shared types and constants for the layer pixel blend.
// No dependencies; used by every module of the block.
package lpb_pkg;

  localparam logic [1:0] CK_COLOR   = 2'd0;
  localparam logic [1:0] CK_HEIGHT  = 2'd1;
  localparam logic [1:0] CK_OPACITY = 2'd2;

  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_ADD      = 3'd1;
  localparam logic [2:0] MODE_MULTIPLY = 3'd2;
  localparam logic [2:0] MODE_SCREEN   = 3'd3;
  localparam logic [2:0] MODE_OVERLAY  = 3'd4;

  // 255 * 255, full weight
  localparam logic [15:0] FULL_W  = 16'd65025;
  // 255 * 65025, common divisor of every lane
  localparam logic [23:0] DIV     = 24'd16581375;
  // floor(2^48 / DIV)
  localparam logic [24:0] RECIP   = 25'd16975370;
  localparam int          RECIP_SH = 48;
  // 255 * 32512, rounding offset of the opacity mask
  localparam logic [31:0] ROUND_K = 32'd8290560;
  // 256 * DIV, numerator at which a lane saturates to 255
  localparam logic [31:0] SAT_LIM = 32'd4244832000;

  localparam int NLANE  = 4;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] layer_opacity;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } res_t;

  // lane numerator = 255*d*(FULL_W-w) + c*w (+ ROUND_K when add_k)
  typedef struct packed {
    logic [7:0]         d;
    logic signed [17:0] c;
    logic               add_k;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic [15:0]       w;
  } job_t;

endpackage

// File: hdl/lpb_front.sv
// Front end: input register, channel_kind register, weight and per-lane setup.
// Uses lpb_pkg; feeds lpb_queue.
module lpb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  output logic          pix_stall,
  input  lpb_pkg::pix_t pix,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data,
  input  logic          q_full,
  output logic          q_push,
  output lpb_pkg::job_t q_job
);

  lpb_pkg::pix_t      hold;
  logic               hold_valid;
  logic [1:0]         channel_kind;
  logic               ld;
  logic [15:0]        w;
  logic signed [9:0]  hc;
  logic signed [17:0] hc_c;
  logic [17:0]        op_c;
  logic [2:0][7:0]    dsts;
  logic [2:0][7:0]    srcs;

  function automatic logic signed [17:0] color_c(input logic [2:0] mode,
                                                 input logic [7:0] d,
                                                 input logic [7:0] s);
    logic [15:0] p;
    logic [8:0]  sum;
    logic [17:0] r;
    if (mode == lpb_pkg::MODE_SCREEN || (mode == lpb_pkg::MODE_OVERLAY && d[7]))
      p = 16'(8'd255 - d) * 16'(8'd255 - s);
    else
      p = 16'(d) * 16'(s);
    sum = 9'(d) + 9'(s);
    unique case (mode)
      lpb_pkg::MODE_ADD:      r = 18'(sum[8] ? 8'd255 : sum[7:0]) * 18'd255;
      lpb_pkg::MODE_MULTIPLY: r = 18'(p);
      lpb_pkg::MODE_SCREEN:   r = 18'(lpb_pkg::FULL_W) - 18'(p);
      lpb_pkg::MODE_OVERLAY:  r = d[7] ? 18'(lpb_pkg::FULL_W) - {1'b0, p, 1'b0}
                                       : {1'b0, p, 1'b0};
      default:                r = 18'(s) * 18'd255;
    endcase
    return $signed(r);
  endfunction

  assign ld        = !hold_valid || !q_full;
  assign pix_stall = !ld;
  assign q_push    = hold_valid && !q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      channel_kind <= lpb_pkg::CK_COLOR;
    end else begin
      if (ld) hold_valid <= pix_valid;
      if (cfg_valid) channel_kind <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && pix_valid) hold <= pix;
  end

  always_comb begin
    w    = 16'(hold.src_alpha) * 16'(hold.layer_opacity);
    hc   = $signed({2'b00, hold.dst_red}) + $signed({2'b00, hold.src_red}) - 10'sd128;
    hc_c = 18'(hc) * 18'sd255;
    op_c = 18'(hold.src_red) * 18'd255;
    dsts = {hold.dst_blue, hold.dst_green, hold.dst_red};
    srcs = {hold.src_blue, hold.src_green, hold.src_red};
    q_job.w = w;
    // alpha lane outside opacity mode: Porter-Duff over is a normal blend with source 255
    q_job.lane[3].d     = hold.dst_alpha;
    q_job.lane[3].c     = $signed(18'(lpb_pkg::FULL_W));
    q_job.lane[3].add_k = 1'b0;
    unique case (channel_kind)
      lpb_pkg::CK_HEIGHT: begin
        for (int i = 0; i < 3; i++) begin
          // zero weight keeps each destination component
          q_job.lane[i].d     = (w == 16'd0) ? dsts[i] : hold.dst_red;
          q_job.lane[i].c     = hc_c;
          q_job.lane[i].add_k = 1'b0;
        end
      end
      lpb_pkg::CK_OPACITY: begin
        for (int i = 0; i < lpb_pkg::NLANE; i++) begin
          q_job.lane[i].d     = hold.dst_red;
          q_job.lane[i].c     = $signed(op_c);
          q_job.lane[i].add_k = 1'b1;
        end
        // zero weight keeps the destination pixel
        if (w == 16'd0) begin
          for (int i = 0; i < 3; i++) q_job.lane[i].d = dsts[i];
          q_job.lane[3].d = hold.dst_alpha;
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          q_job.lane[i].d     = dsts[i];
          q_job.lane[i].c     = color_c(hold.kind, dsts[i], srcs[i]);
          q_job.lane[i].add_k = 1'b0;
        end
      end
    endcase
  end

endmodule

// File: hdl/lpb_queue.sv
// Short job queue between the front end and the arithmetic back end.
// Uses lpb_pkg for the job type and depth.
module lpb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lpb_pkg::job_t push_job,
  input  logic          pop,
  output lpb_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);

  localparam int CW = lpb_pkg::QAW + 1;

  lpb_pkg::job_t          mem [lpb_pkg::QDEPTH];
  logic [lpb_pkg::QAW-1:0] wp;
  logic [lpb_pkg::QAW-1:0] rp;
  logic [CW-1:0]           cnt;

  assign full    = cnt == CW'(lpb_pkg::QDEPTH);
  assign empty   = cnt == '0;
  assign pop_job = mem[rp];

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_job;
  end

endmodule

// File: hdl/lpb_back.sv
// Back end: five-stage lane pipeline, products, sum, reciprocal divide, fix-up.
// Uses lpb_pkg; drains lpb_queue and drives the result word.
module lpb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  output logic          q_pop,
  input  lpb_pkg::job_t q_job,
  output logic          res_valid,
  input  logic          res_stall,
  output lpb_pkg::res_t res
);

  localparam int NL = lpb_pkg::NLANE;

  logic adv;
  logic v2, v3, v4, v5;

  logic [15:0]              iw;
  logic [NL-1:0][23:0]      t1_c, t1;
  logic signed [33:0]       t2_c [NL];
  logic signed [33:0]       t2 [NL];
  logic [NL-1:0]            ak2;
  logic [NL-1:0][31:0]      t1x;
  logic [NL-1:0][31:0]      kv;
  logic signed [34:0]       s_c [NL];
  logic [NL-1:0][31:0]      n3, n4, n5;
  logic [NL-1:0]            neg3, neg4, neg5, sat3, sat4, sat5;
  logic [NL-1:0][56:0]      pr_c;
  logic [NL-1:0][7:0]       qe4, qe5;
  logic [NL-1:0][31:0]      qd5;
  logic [NL-1:0][7:0]       ov;

  assign adv   = !res_valid || !res_stall;
  assign q_pop = adv && !q_empty;
  assign iw    = lpb_pkg::FULL_W - q_job.w;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      t1_c[i] = 24'(q_job.lane[i].d) * 24'(iw);
      t2_c[i] = 34'(q_job.lane[i].c) * $signed({18'b0, q_job.w});
      t1x[i]  = 32'(t1[i]) * 32'd255;
      kv[i]   = ak2[i] ? lpb_pkg::ROUND_K : '0;
      s_c[i]  = $signed({3'b000, t1x[i]}) + 35'(t2[i]) + $signed({3'b000, kv[i]});
      pr_c[i] = 57'(n3[i]) * 57'(lpb_pkg::RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v2        <= !q_empty;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      res_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        t1[i]   <= t1_c[i];
        t2[i]   <= t2_c[i];
        ak2[i]  <= q_job.lane[i].add_k;
        n3[i]   <= s_c[i][31:0];
        neg3[i] <= s_c[i][34];
        sat3[i] <= !s_c[i][34] && (s_c[i][33:0] >= {2'b00, lpb_pkg::SAT_LIM});
        qe4[i]  <= pr_c[i][lpb_pkg::RECIP_SH +: 8];
        n4[i]   <= n3[i];
        neg4[i] <= neg3[i];
        sat4[i] <= sat3[i];
        qd5[i]  <= 32'(qe4[i]) * 32'(lpb_pkg::DIV);
        qe5[i]  <= qe4[i];
        n5[i]   <= n4[i];
        neg5[i] <= neg4[i];
        sat5[i] <= sat4[i];
      end
      res.out_red   <= ov[0];
      res.out_green <= ov[1];
      res.out_blue  <= ov[2];
      res.out_alpha <= ov[3];
    end
  end

  // estimate is exact or one low
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if (neg5[i])
        ov[i] = 8'd0;
      else if (sat5[i])
        ov[i] = 8'd255;
      else
        ov[i] = qe5[i] + 8'(n5[i] >= qd5[i] + 32'(lpb_pkg::DIV));
    end
  end

endmodule

// File: hdl/layer_pixel_blend.sv
// Each pixel word passes the input register, the queue, then the back-end pipeline.
// Throughput: one pixel per cycle, five-stage back-end pipeline, while not stalled.
// A 4-entry queue lets the front accept, until full, while the result is stalled.
// Reset clears all valid bits and the queue; channel_kind returns to color.
// Top level of the layer pixel blend; uses lpb_pkg, lpb_front, lpb_queue, lpb_back.
module layer_pixel_blend (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  output logic          pix_stall,
  input  lpb_pkg::pix_t pix,
  output logic          res_valid,
  input  logic          res_stall,
  output lpb_pkg::res_t res,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data
);

  lpb_pkg::job_t push_job;
  lpb_pkg::job_t pop_job;
  logic          push, pop, full, empty;

  lpb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  lpb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  lpb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (empty),
    .q_pop     (pop),
    .q_job     (pop_job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// File: hdl/lpb_checker.sv
// Port-level checker for layer_pixel_blend, bound to the top level.
// Uses lpb_pkg and the macros in layer_pixel_blend_assert.svh.
`include "layer_pixel_blend_assert.svh"

module lpb_checker (
  input logic          clk,
  input logic          rst,
  input logic          pix_valid,
  input logic          pix_stall,
  input logic          res_valid,
  input logic          res_stall,
  input lpb_pkg::res_t res
);

  // front register, queue and five back stages
  localparam logic [3:0] PEND_MAX = 4'd10;

  logic [3:0] pend;
  logic       in_acc, out_acc;

  assign in_acc  = pix_valid && !pix_stall;
  assign out_acc = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 4'(in_acc) - 4'(out_acc);
    end
  end

  `LPB_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "word not held")
  `LPB_ASSERT_IMPLY(a_no_orphan, res_valid, pend != 4'd0, "result word without a pending pixel")
  `LPB_ASSERT_IMPLY(a_stall_busy, pix_stall, pend != 4'd0, "input stalled with nothing in flight")
  `LPB_ASSERT_IMPLY(a_pend_cap, 1'b1, pend <= PEND_MAX, "more pixels in flight than storage")

endmodule

bind layer_pixel_blend lpb_checker u_lpb_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
